// File: hdl/smdp_pkg.sv
// shared types and constants for the standardized masked dot product
package smdp_pkg;

    // stream data word widths and the dot product width
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 56;
    localparam int DOT_W       = 48;

    // divider geometry
    localparam int DIV_NUM_W   = 48;
    localparam int DIV_DEN_W   = 32;
    localparam int DIV_CNT_W   = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd48;

    // register indexes on the configuration port
    localparam logic [1:0] REG_FREQ_MODE = 2'd0;
    localparam logic [1:0] REG_PLOIDY_X  = 2'd1;
    localparam logic [1:0] REG_PLOIDY_Y  = 2'd2;

    // divider operand select
    typedef enum logic [1:0] {
        DIV_X,
        DIV_Y,
        DIV_MAIN
    } t_div_sel;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIVX,
        S_DIVY,
        S_DIFF,
        S_MUL,
        S_START,
        S_DIVM,
        S_DONE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic     load;
        logic     save_raw;
        logic     div_start;
        t_div_sel div_sel;
        logic     div_step;
        logic     save_vx;
        logic     save_vy;
        logic     diff;
        logic     mul;
        logic     acc;
        logic     set_zero;
        logic     emit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic masked;
        logic sd_zero;
        logic freq;
        logic last;
        logic div_done;
        logic out_busy;
    } t_sts;

endpackage

// File: hdl/smdp_ctrl.sv
// controller state machine sequencing one locus through the datapath
module smdp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  smdp_pkg::t_sts i_sts,
    output smdp_pkg::t_cmd o_cmd
);
    import smdp_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.masked || i_sts.sd_zero) n_state = S_DONE;
                else if (i_sts.freq) n_state = S_DIVX;
                else n_state = S_DIFF;
            end
            S_DIVX: begin
                if (i_sts.div_done) n_state = S_DIVY;
            end
            S_DIVY: begin
                if (i_sts.div_done) n_state = S_DIFF;
            end
            S_DIFF:  n_state = S_MUL;
            S_MUL:   n_state = S_START;
            S_START: n_state = S_DIVM;
            S_DIVM: begin
                if (i_sts.div_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.last || !i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CHECK: begin
                if (!i_sts.masked && i_sts.sd_zero) o_cmd.set_zero = 1'b1;
                if (!i_sts.masked && !i_sts.sd_zero) begin
                    if (i_sts.freq) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = DIV_X;
                    end else begin
                        o_cmd.save_raw  = 1'b1;
                    end
                end
            end
            S_DIVX: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.save_vx   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_Y;
                end
            end
            S_DIVY: begin
                o_cmd.div_step = 1'b1;
                o_cmd.save_vy  = i_sts.div_done;
            end
            S_DIFF: o_cmd.diff = 1'b1;
            S_MUL:  o_cmd.mul  = 1'b1;
            S_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_MAIN;
            end
            S_DIVM: begin
                o_cmd.div_step = 1'b1;
                o_cmd.acc      = i_sts.div_done;
            end
            S_DONE: begin
                o_cmd.emit = i_sts.last && !i_sts.out_busy;
            end
            default: o_cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    // a result leaves only for a locus marked last, into a free output slot
    a_emit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (i_sts.last && !i_sts.out_busy))
        else $error("emit without last or with busy output");

    // an accepted request is checked in the next cycle
    a_load_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_CHECK))
        else $error("request not checked after load");

    // accumulation only on a finished division
    a_acc_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.acc |-> i_sts.div_done)
        else $error("accumulate before divider done");
`endif

endmodule

// File: hdl/smdp_datapath.sv
// datapath: operand latch, shared restoring divider, multipliers, accumulator
module smdp_datapath #(
    parameter int ACC_WIDTH = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  smdp_pkg::t_cmd                    i_cmd,
    output smdp_pkg::t_sts                    o_sts,
    input  logic [smdp_pkg::IN_DATA_W-1:0]    i_in_data,
    input  logic                              i_in_last,
    input  logic                              i_freq_mode,
    input  logic [3:0]                        i_ploidy_x,
    input  logic [3:0]                        i_ploidy_y,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [smdp_pkg::OUT_DATA_W-1:0]   o_out_data
);
    import smdp_pkg::*;

    localparam int SW = ((ACC_WIDTH > 48) ? ACC_WIDTH : 48) + 2;
    localparam logic signed [SW-1:0] ACC_HI =
        {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] ACC_LO = ~ACC_HI;

    // latched request
    logic [3:0]  r_cx, r_cy;
    logic        r_masked, r_last;
    logic [15:0] r_mean, r_sd;

    // operands
    logic [15:0] r_vx, r_vy, r_ax, r_ay;
    logic        r_neg;
    logic [31:0] r_prod, r_sdsq;

    // divider
    logic [DIV_DEN_W-1:0] r_den, r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;

    // accumulator and flags
    logic [ACC_WIDTH-1:0] r_acc;
    logic                 r_ovf, r_zsd;
    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [3:0]           px, py, pdiv;
    logic [3:0]           cdiv;
    logic [DIV_NUM_W-1:0] num_sel;
    logic [DIV_DEN_W-1:0] den_sel;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 ge;
    logic signed [16:0]   dx, dy;
    logic signed [48:0]   term;
    logic signed [SW-1:0] acc_ext, sum;

    // zero ploidy acts as one
    assign px   = (i_ploidy_x == 4'd0) ? 4'd1 : i_ploidy_x;
    assign py   = (i_ploidy_y == 4'd0) ? 4'd1 : i_ploidy_y;
    assign pdiv = (i_cmd.div_sel == DIV_Y) ? py : px;
    assign cdiv = (i_cmd.div_sel == DIV_Y) ? r_cy : r_cx;

    // divider operand select
    always_comb begin
        case (i_cmd.div_sel)
            DIV_MAIN: begin
                num_sel = {r_prod, 16'd0};
                den_sel = r_sdsq;
            end
            default: begin
                num_sel = {32'd0, {cdiv, 12'd0} + {13'd0, pdiv[3:1]}};
                den_sel = {28'd0, pdiv};
            end
        endcase
    end

    // one restoring step
    assign rem_sh = {r_rem, r_quo[DIV_NUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_den});

    // centred differences
    assign dx = $signed({1'b0, r_vx}) - $signed({1'b0, r_mean});
    assign dy = $signed({1'b0, r_vy}) - $signed({1'b0, r_mean});

    // signed term and saturating sum
    assign term    = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign acc_ext = {{(SW-ACC_WIDTH){r_acc[ACC_WIDTH-1]}}, r_acc};
    assign sum     = acc_ext + {{(SW-49){term[48]}}, term};

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx     <= i_in_data[3:0];
            r_cy     <= i_in_data[7:4];
            r_masked <= i_in_data[8] | i_in_data[9];
            r_mean   <= i_in_data[25:10];
            r_sd     <= i_in_data[41:26];
            r_last   <= i_in_last;
        end
    end

    // operand preparation and products
    always_ff @(posedge i_clk) begin
        if (i_cmd.save_raw) begin
            r_vx <= {r_cx, 12'd0};
            r_vy <= {r_cy, 12'd0};
        end
        if (i_cmd.save_vx) r_vx <= r_quo[15:0];
        if (i_cmd.save_vy) r_vy <= r_quo[15:0];
        if (i_cmd.diff) begin
            r_ax  <= dx[16] ? 16'(-dx) : dx[15:0];
            r_ay  <= dy[16] ? 16'(-dy) : dy[15:0];
            r_neg <= dx[16] ^ dy[16];
        end
        if (i_cmd.mul) begin
            r_prod <= r_ax * r_ay;
            r_sdsq <= r_sd * r_sd;
        end
    end

    // iterative divider, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_cnt <= DIV_STEPS;
        end else if (i_cmd.div_step && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo <= num_sel;
            r_den <= den_sel;
            r_rem <= '0;
        end else if (i_cmd.div_step && r_cnt != '0) begin
            r_quo <= {r_quo[DIV_NUM_W-2:0], ge};
            r_rem <= ge ? DIV_DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DIV_DEN_W-1:0];
        end
    end

    // accumulator, flags and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_zsd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) r_out_valid <= 1'b0;
            if (i_cmd.set_zero) r_zsd <= 1'b1;
            if (i_cmd.acc) begin
                if (sum > ACC_HI) begin
                    r_acc <= ACC_HI[ACC_WIDTH-1:0];
                    r_ovf <= 1'b1;
                end else if (sum < ACC_LO) begin
                    r_acc <= ACC_LO[ACC_WIDTH-1:0];
                    r_ovf <= 1'b1;
                end else begin
                    r_acc <= sum[ACC_WIDTH-1:0];
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_acc       <= '0;
                r_ovf       <= 1'b0;
                r_zsd       <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {6'd0, r_zsd, r_ovf, acc_ext[DOT_W-1:0]};
        end
    end

    // status to controller
    assign o_sts.masked   = r_masked;
    assign o_sts.sd_zero  = (r_sd == 16'd0);
    assign o_sts.freq     = i_freq_mode;
    assign o_sts.last     = r_last;
    assign o_sts.div_done = (r_cnt == '0);
    assign o_sts.out_busy = r_out_valid & ~i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: hdl/standardized_masked_dot_product.sv
// top level of the standardized masked dot product block
//
// Usage: one locus per request on the slave stream, the vector's final
// locus marked by s_axis_tlast. Each unmasked locus with nonzero sd adds
// ((x-mean)/sd)*((y-mean)/sd) in signed Q.16 to a saturating accumulator.
// On the last locus one result goes out on the master stream: the total,
// a saturation flag and a zero-sd flag; accumulator and flags then clear.
// Raw mode runs each locus through the shared one-bit-per-cycle restoring
// divider for the term division; frequency mode first divides both counts
// by ploidy in it; a masked or zero-sd locus skips it. One locus at a time.
// The result sits in an output register; while the receiver stalls the
// block keeps taking loci and only holds at the next last locus.
// Reset (synchronous, active low) clears accumulator, flags, the output
// valid and sets freq_mode 0, ploidy_x 2, ploidy_y 2. Registers on the
// APB port: freq_mode at 0x0, ploidy_x at 0x4, ploidy_y at 0x8.
module standardized_masked_dot_product #(
    parameter int ACC_WIDTH = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // count_x[3:0], count_y[7:4], missing_x[8], missing_y[9],
    // locus_mean[25:10], locus_sd[41:26], zero fill above
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // dot_product[47:0], overflowed[48], zero_sd_seen[49], zero fill above
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import smdp_pkg::*;

    t_cmd       cmd;
    t_sts       sts;
    logic       r_freq_mode;
    logic [3:0] r_ploidy_x, r_ploidy_y;
    logic       cfg_we;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_mode <= 1'b0;
            r_ploidy_x  <= 4'd2;
            r_ploidy_y  <= 4'd2;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_FREQ_MODE: r_freq_mode <= pwdata[0];
                REG_PLOIDY_X:  r_ploidy_x  <= pwdata[3:0];
                REG_PLOIDY_Y:  r_ploidy_y  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        case (paddr[3:2])
            REG_FREQ_MODE: prdata = {31'd0, r_freq_mode};
            REG_PLOIDY_X:  prdata = {28'd0, r_ploidy_x};
            REG_PLOIDY_Y:  prdata = {28'd0, r_ploidy_y};
            default:       prdata = 32'd0;
        endcase
    end

    // controller
    smdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    smdp_datapath #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .i_freq_mode (r_freq_mode),
        .i_ploidy_x  (r_ploidy_x),
        .i_ploidy_y  (r_ploidy_y),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// File: tb/tb.sv
// testbench for the standardized masked dot product block
`timescale 1ns / 100ps

module tb;
    import smdp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    typedef struct packed {
        logic [47:0] dot;
        logic        ovf;
        logic        zsd;
    } t_total;

    localparam logic signed [47:0] ACC_HI = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] ACC_LO = {1'b1, {47{1'b0}}};

    // predictor copy of configuration and state
    logic               cfg_freq;
    logic [3:0]         cfg_px;
    logic [3:0]         cfg_py;
    logic signed [47:0] sum_acc;
    logic               sum_ovf;
    logic               sum_zsd;

    t_total totals_q[$];
    int     fail_cnt;
    logic   hold_off;
    int     gap_max;

    standardized_masked_dot_product i_dut (.*);

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [16:0] count_q12(logic [3:0] cnt, logic [3:0] pl);
        logic [16:0] v;
        logic [16:0] p;
        v = {1'b0, cnt, 12'd0};
        if (cfg_freq) begin
            p = (pl == 0) ? 17'd1 : {13'd0, pl};
            v = (v + (p >> 1)) / p;
        end
        return v;
    endfunction

    // update the running total for one locus, queue a total on last
    task automatic predict_locus(logic [3:0] cx, logic [3:0] cy, logic mx, logic my,
                                 logic [15:0] mean, logic [15:0] sd, logic lst);
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic [63:0]        mag;
        logic [63:0]        den;
        logic signed [63:0] term;
        logic signed [63:0] nxt;
        t_total             tot;
        if (!mx && !my) begin
            if (sd == 0) begin
                sum_zsd = 1'b1;
            end else begin
                dx = $signed({1'b0, count_q12(cx, cfg_px)}) - $signed({2'b0, mean});
                dy = $signed({1'b0, count_q12(cy, cfg_py)}) - $signed({2'b0, mean});
                mag = (64'(dx < 0 ? -dx : dx) * 64'(dy < 0 ? -dy : dy)) << 16;
                den = 64'(sd) * 64'(sd);
                mag = mag / den;
                term = ((dx < 0) != (dy < 0)) ? -$signed(mag) : $signed(mag);
                nxt = 64'(sum_acc) + term;
                if (nxt > 64'(ACC_HI)) begin
                    sum_acc = ACC_HI;
                    sum_ovf = 1'b1;
                end else if (nxt < 64'(ACC_LO)) begin
                    sum_acc = ACC_LO;
                    sum_ovf = 1'b1;
                end else begin
                    sum_acc = nxt[47:0];
                end
            end
        end
        if (lst) begin
            tot.dot = sum_acc;
            tot.ovf = sum_ovf;
            tot.zsd = sum_zsd;
            totals_q.push_back(tot);
            sum_acc = 0;
            sum_ovf = 1'b0;
            sum_zsd = 1'b0;
        end
    endtask

    // send one locus request, with a random gap first
    task automatic send_locus(logic [3:0] cx, logic [3:0] cy, logic mx, logic my,
                              logic [15:0] mean, logic [15:0] sd, logic lst);
        int gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {6'd0, sd, mean, my, mx, cy, cx};
        s_axis_tlast  <= lst;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_locus(cx, cy, mx, my, mean, sd, lst);
    endtask

    task automatic send_random(int n_loci, int end_bias);
        logic [15:0] mean;
        logic [15:0] sd;
        for (int i = 0; i < n_loci; i++) begin
            mean = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'hffff) >> $urandom_range(0, 4));
            case ($urandom_range(0, 9))
                0: sd = 16'd0;
                1: sd = 16'd1;
                2: sd = 16'($urandom_range(1, 64));
                default: sd = 16'($urandom_range(1, 16'hffff));
            endcase
            send_locus(4'($urandom), 4'($urandom), $urandom_range(0, 7) == 0,
                       $urandom_range(0, 7) == 0, mean, sd,
                       $urandom_range(0, end_bias) == 0 || i == n_loci - 1);
        end
    endtask

    task automatic wait_drain;
        int guard;
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (totals_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (400) @(posedge i_clk);
    endtask

    // apb write, then read back
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_FREQ_MODE: cfg_freq = val[0];
            REG_PLOIDY_X:  cfg_px   = val[3:0];
            default:       cfg_py   = val[3:0];
        endcase
    endtask

    task automatic set_config(logic fm, logic [3:0] px, logic [3:0] py);
        wait_drain();
        write_reg(REG_FREQ_MODE, {31'd0, fm});
        write_reg(REG_PLOIDY_X, {28'd0, px});
        write_reg(REG_PLOIDY_Y, {28'd0, py});
    endtask

    // extremes, masks, zero sd and a last on a masked locus
    task automatic test_directed;
        send_locus(4'd0, 4'd0, 0, 0, 16'd0, 16'd1, 0);
        send_locus(4'd15, 4'd15, 0, 0, 16'd0, 16'd1, 1);
        send_locus(4'd15, 4'd0, 0, 0, 16'hffff, 16'hffff, 0);
        send_locus(4'd0, 4'd15, 0, 0, 16'hffff, 16'd1, 1);
        send_locus(4'd3, 4'd5, 1, 0, 16'h1000, 16'd0, 0);
        send_locus(4'd3, 4'd5, 0, 1, 16'h1000, 16'h1000, 1);
        send_locus(4'd7, 4'd9, 0, 0, 16'h2000, 16'd0, 0);
        send_locus(4'd8, 4'd2, 1, 1, 16'h1234, 16'h0800, 1);
        // positive saturation, then a vector that stays in range
        repeat (4) send_locus(4'd15, 4'd15, 0, 0, 16'd0, 16'd1, 0);
        send_locus(4'd15, 4'd15, 0, 0, 16'd0, 16'd1, 1);
        repeat (4) send_locus(4'd15, 4'd0, 0, 0, 16'd0, 16'd1, 0);
        send_locus(4'd15, 4'd0, 0, 0, 16'hffff, 16'd1, 1);
    endtask

    task automatic test_random_raw;
        set_config(1'b0, 4'd2, 4'd2);
        send_random(300, 6);
    endtask

    task automatic test_freq_settings;
        set_config(1'b1, 4'd2, 4'd2);
        send_random(120, 5);
        set_config(1'b1, 4'd0, 4'd15);
        send_locus(4'd15, 4'd15, 0, 0, 16'h1000, 16'h0001, 1);
        send_random(80, 5);
        set_config(1'b1, 4'd15, 4'd1);
        send_random(80, 5);
        set_config(1'b1, 4'd3, 4'd10);
        send_random(80, 5);
        set_config(1'b0, 4'd15, 4'd0);
        send_random(200, 5);
    endtask

    // receiver held off while loci keep coming
    task automatic test_back_pressure;
        set_config(1'b0, 4'd5, 4'd6);
        gap_max = 0;
        hold_off = 1'b1;
        fork
            repeat (3000) @(posedge i_clk);
        join_none
        send_random(60, 2);
        gap_max = 6;
        send_random(300, 8);
    endtask

    // receiver stall pattern, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_off) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
        end
    end

    initial begin
        int cnt;
        wait (hold_off);
        cnt = 0;
        while (cnt < 3000) begin
            @(posedge i_clk);
            cnt++;
        end
        hold_off = 1'b0;
    end

    // result checker
    always @(posedge i_clk) begin
        t_total got;
        t_total want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.dot = m_axis_tdata[47:0];
            got.ovf = m_axis_tdata[48];
            got.zsd = m_axis_tdata[49];
            if (totals_q.size() == 0) begin
                $error("unexpected total %h", m_axis_tdata);
                fail_cnt++;
            end else begin
                want = totals_q.pop_front();
                if (got.dot !== want.dot) begin
                    $error("dot_product expected %h actual %h", want.dot, got.dot);
                    fail_cnt++;
                end
                if (got.ovf !== want.ovf) begin
                    $error("overflowed expected %b actual %b", want.ovf, got.ovf);
                    fail_cnt++;
                end
                if (got.zsd !== want.zsd) begin
                    $error("zero_sd_seen expected %b actual %b", want.zsd, got.zsd);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_off      = 1'b0;
        fail_cnt      = 0;
        gap_max       = 4;
        cfg_freq      = 1'b0;
        cfg_px        = 4'd2;
        cfg_py        = 4'd2;
        sum_acc       = 0;
        sum_ovf       = 1'b0;
        sum_zsd       = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_raw();
        test_freq_settings();
        test_back_pressure();
        wait_drain();
        if (fail_cnt == 0 && totals_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("tb failed");
        $finish;
    end

endmodule
